>>> rtl/flow_table_nth_packet_dropper_top_macros.svh
// Assertion macros used by the flow table dropper top level.
`ifndef FLOW_TABLE_NTH_PACKET_DROPPER_TOP_MACROS_SVH
`define FLOW_TABLE_NTH_PACKET_DROPPER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FTNPD_ASSERT_NOW(name, ck, rn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define FTNPD_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ftnpd_pkg.sv
// Types and constants of the flow table dropper.
package ftnpd_pkg;

	localparam int TABLE_ENTRIES = 64;

	localparam logic [7:0] UDP_PROTO        = 8'd17;
	localparam logic [3:0] UDP_HEADER_BYTES = 4'd8;

	typedef enum logic [1:0] {
		KIND_NOT_FLOOD  = 2'd0,
		KIND_FLOOD_PASS = 2'd1,
		KIND_FLOOD_DROP = 2'd2,
		KIND_TABLE_FULL = 2'd3
	} kind_t;

	typedef enum logic [7:0] {
		CFG_FLOOD_PORT  = 8'd0,
		CFG_FLOOD_TYPE  = 8'd1,
		CFG_MIN_PAYLOAD = 8'd2,
		CFG_DROP_PERIOD = 8'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] flood_port;
		logic [7:0]  flood_type;
		logic [15:0] min_payload_len;
		logic [7:0]  drop_period;
	} cfg_t;

	typedef struct packed {
		logic [31:0] packet_tag;
		logic [7:0]  ip_protocol;
		logic [3:0]  ip_header_words;
		logic [15:0] ip_total_len;
		logic [15:0] udp_dest_port;
		logic [7:0]  message_type;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
	} pkt_beat_t;

	typedef struct packed {
		logic [31:0] verdict_tag;
		logic        drop;
		kind_t       verdict_kind;
		logic [31:0] flow_packet_number;
	} vrd_beat_t;

	// Query travelling down the cell row.
	typedef struct packed {
		logic        vld;
		logic        flood;
		logic        done;
		logic [31:0] tag;
		logic [31:0] src;
		logic [31:0] dst;
		logic        drop;
		kind_t       kind;
		logic [31:0] number;
	} token_t;

endpackage

>>> rtl/ftnpd_cfg_regs.sv
// Configuration register file of the flow table dropper.
module ftnpd_cfg_regs
	import ftnpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [7:0]  wr_index,
	input  logic [15:0] wr_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flood_port      <= '0;
			cfg_q.flood_type      <= '0;
			cfg_q.min_payload_len <= '0;
			cfg_q.drop_period     <= 8'd3;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_FLOOD_PORT:  cfg_q.flood_port      <= wr_data;
				CFG_FLOOD_TYPE:  cfg_q.flood_type      <= wr_data[7:0];
				CFG_MIN_PAYLOAD: cfg_q.min_payload_len <= wr_data;
				CFG_DROP_PERIOD: cfg_q.drop_period     <= wr_data[7:0];
				default: ; // unknown index: ignored
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/ftnpd_cell.sv
// One flow table entry with its slot of the query chain.
module ftnpd_cell
	import ftnpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic [7:0] drop_period,
	input  token_t     tok_i,
	output token_t     tok_o,
	output logic       used
);

	logic        valid_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;
	logic [7:0]  phase_q;
	logic [31:0] count_q;
	token_t      tok_q;

	logic        take;
	logic [7:0]  phase_old;
	logic [31:0] count_old;
	logic [7:0]  limit;
	logic        hit_drop;
	logic [31:0] number;
	token_t      tok_n;

	// Matching entry, or the first free one (entries fill in order).
	assign take = tok_i.vld && tok_i.flood && !tok_i.done &&
		(!valid_q || (src_q == tok_i.src && dst_q == tok_i.dst));

	assign phase_old = valid_q ? phase_q : 8'd0;
	assign count_old = valid_q ? count_q : 32'd0;
	// period 0 behaves as 1
	assign limit     = (drop_period == 8'd0) ? 8'd0 : drop_period - 8'd1;
	assign hit_drop  = phase_old >= limit;
	assign number    = count_old + 32'd1;

	always_comb begin
		tok_n = tok_i;
		if (take) begin
			tok_n.done   = 1'b1;
			tok_n.drop   = hit_drop;
			tok_n.kind   = hit_drop ? KIND_FLOOD_DROP : KIND_FLOOD_PASS;
			tok_n.number = number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else if (adv) begin
			tok_q <= tok_n;
			if (take) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (take) begin
				src_q   <= tok_i.src;
				dst_q   <= tok_i.dst;
				count_q <= number;
				phase_q <= hit_drop ? 8'd0 : phase_old + 8'd1;
			end
		end
	end

	assign tok_o = tok_q;
	assign used  = valid_q;

endmodule

>>> rtl/flow_table_nth_packet_dropper_top.sv
// Top level of the flood packet dropper with its per-flow table.
//
//  channel | direction | handshake             | beat
//  --------+-----------+-----------------------+-----------------------------
//  pkt     | in        | pkt_valid / pkt_ready | pkt_beat_t header fields
//  vrd     | out       | vrd_valid / vrd_ready | vrd_beat_t verdict
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data (write)
//
// A beat is classified as it is accepted, then walks the row of TABLE_ENTRIES
// cells, one cell per cycle while vrd does not stall, then lands in the output
// register. The row is a pipeline, so a new beat enters every cycle unless vrd
// stalls; beats reach each cell in order, so lookups and inserts see the table
// exactly as earlier beats left it.
// Reset clears the config to its defaults and all entry valid bits at once;
// no clearing pass. cfg_ready is always high.
// A stall on vrd freezes the whole row (pkt_ready low) until the output
// register drains.
`include "flow_table_nth_packet_dropper_top_macros.svh"
module flow_table_nth_packet_dropper_top
	import ftnpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pkt_valid,
	output logic        pkt_ready,
	input  pkt_beat_t   pkt,
	output logic        vrd_valid,
	input  logic        vrd_ready,
	output vrd_beat_t   vrd,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t      cfg;
	logic      adv;
	token_t    tok_s1;
	token_t    tok_in;
	token_t    chain [TABLE_ENTRIES+1];
	logic [TABLE_ENTRIES-1:0] used;
	logic      vrd_valid_q;
	vrd_beat_t vrd_q;
	token_t    tok_last;

	// Classification
	logic [6:0]  hdr_len;
	logic [15:0] payload_len;
	logic        is_flood;

	assign cfg_ready = 1'b1;

	ftnpd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Whole pipe moves when the output register is free or being drained.
	assign adv       = !vrd_valid_q || vrd_ready;
	assign pkt_ready = adv;

	// IP header bytes plus the UDP header; short packets never count as flood.
	assign hdr_len     = {1'b0, pkt.ip_header_words, 2'b00} + {3'b000, UDP_HEADER_BYTES};
	assign payload_len = pkt.ip_total_len - {9'd0, hdr_len};
	assign is_flood    = (pkt.ip_protocol == UDP_PROTO) &&
		(pkt.udp_dest_port == cfg.flood_port) &&
		(pkt.ip_total_len >= {9'd0, hdr_len}) &&
		(payload_len >= cfg.min_payload_len) &&
		(pkt.message_type == cfg.flood_type);

	always_comb begin
		tok_in.vld    = pkt_valid;
		tok_in.flood  = is_flood;
		tok_in.done   = 1'b0;
		tok_in.tag    = pkt.packet_tag;
		tok_in.src    = pkt.src_addr;
		tok_in.dst    = pkt.dst_addr;
		tok_in.drop   = 1'b0;
		tok_in.kind   = KIND_NOT_FLOOD;
		tok_in.number = 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else if (adv) begin
			tok_s1 <= tok_in;
		end
	end

	assign chain[0] = tok_s1;

	// The row of table cells.
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		ftnpd_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.adv         (adv),
			.drop_period (cfg.drop_period),
			.tok_i       (chain[i]),
			.tok_o       (chain[i+1]),
			.used        (used[i])
		);
	end

	assign tok_last = chain[TABLE_ENTRIES];

	// Output register; a flood beat that found no cell means the table is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vrd_valid_q <= 1'b0;
		end else if (adv) begin
			vrd_valid_q <= tok_last.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vrd_q.verdict_tag <= tok_last.tag;
			if (tok_last.flood && !tok_last.done) begin
				vrd_q.drop               <= 1'b0;
				vrd_q.verdict_kind       <= KIND_TABLE_FULL;
				vrd_q.flow_packet_number <= 32'd0;
			end else begin
				vrd_q.drop               <= tok_last.drop;
				vrd_q.verdict_kind       <= tok_last.kind;
				vrd_q.flow_packet_number <= tok_last.number;
			end
		end
	end

	assign vrd_valid = vrd_valid_q;
	assign vrd       = vrd_q;

	// Entries fill from cell 0 upward with no holes.
	`FTNPD_ASSERT_NOW(a_used_contiguous, clk, arst_n, 1'b1,
		(used & (used + 1'b1)) == '0, "table entries not contiguous")
	// Drop flag agrees with the verdict kind.
	`FTNPD_ASSERT_NOW(a_drop_kind, clk, arst_n, vrd_valid,
		vrd.drop == (vrd.verdict_kind == KIND_FLOOD_DROP), "drop and kind disagree")
	// Non-flood and table-full verdicts carry no packet number.
	`FTNPD_ASSERT_NOW(a_no_number, clk, arst_n,
		vrd_valid && (vrd.verdict_kind == KIND_NOT_FLOOD ||
		vrd.verdict_kind == KIND_TABLE_FULL),
		vrd.flow_packet_number == 32'd0, "number on non-counted verdict")
	// A full table stays full.
	`FTNPD_ASSERT_NEXT(a_full_sticky, clk, arst_n, &used, &used, "entry lost")

endmodule
